FILE: src/binary_max_heap_queue_defines.svh
// ----------------------------------------------------------------------------
// Binary max-heap queue assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication
`define BHQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bhq: check failed");

// next-cycle implication
`define BHQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bhq: check failed");

`endif

FILE: src/bhq_pkg.sv
// ----------------------------------------------------------------------------
// Binary max-heap queue package
// Shared defaults, operation and status codes, cell control type.
// ----------------------------------------------------------------------------
package bhq_pkg;

  localparam int unsigned HEAP_DEPTH_DEF = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } bhq_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bhq_status_e;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } bhq_op_t;

endpackage

FILE: src/bhq_if.sv
// ----------------------------------------------------------------------------
// Binary max-heap queue channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface bhq_req_if #(
  parameter int unsigned DATA_WIDTH = bhq_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface bhq_rsp_if #(
  parameter int unsigned DATA_WIDTH  = bhq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = $clog2(bhq_pkg::HEAP_DEPTH_DEF + 1)
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] top_value;
  logic [COUNT_WIDTH-1:0]       count;
  logic                         empty_res;
  logic [1:0]                   status;

  modport source (output valid, output top_value, output count, output empty_res,
                  output status, input ready);
  modport sink   (input valid, input top_value, input count, input empty_res,
                  input status, output ready);
endinterface

FILE: src/bhq_cell.sv
// ----------------------------------------------------------------------------
// Binary max-heap queue cell
// One slot of the sorted chain; inserts, shifts down on push, up on pop.
// ----------------------------------------------------------------------------
module bhq_cell #(
  parameter int unsigned DATA_WIDTH = bhq_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bhq_pkg::bhq_op_t             op_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic signed [DATA_WIDTH-1:0] left_data_i,
  input  logic                         left_occ_i,
  input  logic                         left_gt_i,
  input  logic signed [DATA_WIDTH-1:0] right_data_i,
  input  logic                         right_occ_i,
  output logic signed [DATA_WIDTH-1:0] data_o,
  output logic                         occ_o,
  output logic                         gt_o
);

  logic signed [DATA_WIDTH-1:0] data_d, data_q;
  logic                         occ_d, occ_q;

  // free slot counts as minus infinity
  assign gt_o   = !occ_q || (value_i > data_q);
  assign data_o = data_q;
  assign occ_o  = occ_q;

  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    if (op_i.push) begin
      if (gt_o) begin
        data_d = left_gt_i ? left_data_i : value_i;
      end
      occ_d = left_occ_i;
    end else if (op_i.pop) begin
      data_d = right_data_i;
      occ_d  = right_occ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

FILE: src/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// Binary max-heap queue
// Max priority queue built as a sorted chain of HEAP_DEPTH cells.
// ----------------------------------------------------------------------------
// Each request is a push of a signed value or a pop of the largest entry and
// returns one response with the new largest value (0 when empty), the entry
// count, an empty flag and a status (push dropped when full, pop on empty).
// The cells keep the entries sorted, largest in the first cell; a push makes
// every cell compare against the new value, and the cells past the insertion
// point shift down by one in the same cycle; a pop shifts the whole chain by
// one. The response is registered, valid in the cycle after acceptance; a
// new request is taken in the cycle the pending response is taken. No
// clearing pass is needed after reset.
module binary_max_heap_queue #(
  parameter int unsigned HEAP_DEPTH  = bhq_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = bhq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = $clog2(HEAP_DEPTH + 1)
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bhq_req_if.sink  req_i,
  bhq_rsp_if.source rsp_o
);

  logic signed [DATA_WIDTH-1:0] cell_data [HEAP_DEPTH];
  logic [HEAP_DEPTH-1:0]        cell_occ;
  logic [HEAP_DEPTH-1:0]        cell_gt;

  bhq_pkg::bhq_op_t     op;
  bhq_pkg::bhq_status_e status_d, status_q;
  logic [COUNT_WIDTH-1:0] count_d, count_q;
  logic                   rsp_valid_d, rsp_valid_q;
  logic                   accept, full, empty;

  assign full   = cell_occ[HEAP_DEPTH-1];
  assign empty  = !cell_occ[0];
  assign accept = req_i.valid && req_i.ready;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    op.push  = accept && (req_i.mode == bhq_pkg::MODE_PUSH) && !full;
    op.pop   = accept && (req_i.mode == bhq_pkg::MODE_POP) && !empty;
    status_d = status_q;
    count_d  = count_q;
    if (accept) begin
      status_d = bhq_pkg::ST_OK;
      if (req_i.mode == bhq_pkg::MODE_PUSH && full) begin
        status_d = bhq_pkg::ST_FULL;
      end else if (req_i.mode == bhq_pkg::MODE_POP && empty) begin
        status_d = bhq_pkg::ST_EMPTY;
      end
    end
    if (op.push) begin
      count_d = count_q + COUNT_WIDTH'(1);
    end else if (op.pop) begin
      count_d = count_q - COUNT_WIDTH'(1);
    end
    rsp_valid_d = rsp_valid_q;
    if (accept) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_data, right_data;
    logic                         left_occ, left_gt, right_occ;

    if (i == 0) begin : g_head
      assign left_data = req_i.value;
      assign left_occ  = 1'b1;
      assign left_gt   = 1'b0;
    end else begin : g_body
      assign left_data = cell_data[i-1];
      assign left_occ  = cell_occ[i-1];
      assign left_gt   = cell_gt[i-1];
    end

    if (i == HEAP_DEPTH - 1) begin : g_tail
      assign right_data = '0;
      assign right_occ  = 1'b0;
    end else begin : g_next
      assign right_data = cell_data[i+1];
      assign right_occ  = cell_occ[i+1];
    end

    bhq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .value_i      (req_i.value),
      .left_data_i  (left_data),
      .left_occ_i   (left_occ),
      .left_gt_i    (left_gt),
      .right_data_i (right_data),
      .right_occ_i  (right_occ),
      .data_o       (cell_data[i]),
      .occ_o        (cell_occ[i]),
      .gt_o         (cell_gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= bhq_pkg::ST_OK;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      status_q    <= status_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // state only moves on an accepted request, so a pending response must be taken first
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.top_value = empty ? '0 : cell_data[0];
  assign rsp_o.count     = count_q;
  assign rsp_o.empty_res = empty;
  assign rsp_o.status    = status_q;

endmodule

FILE: src/bhq_checker.sv
// ----------------------------------------------------------------------------
// Binary max-heap queue checker
// Port-level checks on response consistency and request/response timing.
// ----------------------------------------------------------------------------
`include "binary_max_heap_queue_defines.svh"

module bhq_checker #(
  parameter int unsigned HEAP_DEPTH  = bhq_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = bhq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = $clog2(HEAP_DEPTH + 1)
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic signed [DATA_WIDTH-1:0] rsp_top_value_i,
  input logic [COUNT_WIDTH-1:0]       rsp_count_i,
  input logic                         rsp_empty_res_i,
  input logic [1:0]                   rsp_status_i
);

  `BHQ_ASSERT_NOW(a_empty_count, rsp_valid_i, rsp_empty_res_i == (rsp_count_i == '0))
  `BHQ_ASSERT_NOW(a_empty_top, rsp_valid_i && rsp_empty_res_i, rsp_top_value_i == '0)
  `BHQ_ASSERT_NOW(a_full_count, rsp_valid_i && (rsp_status_i == bhq_pkg::ST_FULL), rsp_count_i == COUNT_WIDTH'(HEAP_DEPTH))
  `BHQ_ASSERT_NXT(a_req_rsp, req_valid_i && req_ready_i, rsp_valid_i)
  `BHQ_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_top_value_i) && $stable(rsp_count_i))

endmodule

bind binary_max_heap_queue bhq_checker #(
  .HEAP_DEPTH  (HEAP_DEPTH),
  .DATA_WIDTH  (DATA_WIDTH),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_bhq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_top_value_i (rsp_o.top_value),
  .rsp_count_i     (rsp_o.count),
  .rsp_empty_res_i (rsp_o.empty_res),
  .rsp_status_i    (rsp_o.status)
);
